// File: src/aff2d_pkg.sv
// Shared constants and helpers for the 2D affine inverse pipeline.
package aff2d_pkg;

  localparam int WORD_BITS_DEF     = 32;
  localparam int FRACTION_BITS_DEF = 16;
  localparam int LANES             = 6;

  // Lane order matches the inverse coefficient order
  localparam int LANE_A = 0;
  localparam int LANE_B = 1;
  localparam int LANE_C = 2;
  localparam int LANE_D = 3;
  localparam int LANE_E = 4;
  localparam int LANE_F = 5;

  // Width of a shifted numerator magnitude: scale terms use w+2f, translations 2w+f
  function automatic int num_bits(input int w, input int f);
    return ((w + 2 * f) > (2 * w + f)) ? (w + 2 * f) : (2 * w + f);
  endfunction

endpackage

// File: src/aff2d_if.sv
// Item channel interfaces: transform coefficients in, inverse coefficients out.
interface aff2d_in_if #(parameter int W = 32);
  logic                valid;
  logic                ready;
  logic signed [W-1:0] coef_a;
  logic signed [W-1:0] coef_b;
  logic signed [W-1:0] coef_c;
  logic signed [W-1:0] coef_d;
  logic signed [W-1:0] coef_e;
  logic signed [W-1:0] coef_f;
  modport source (output valid, coef_a, coef_b, coef_c, coef_d, coef_e, coef_f,
                  input ready);
  modport sink (input valid, coef_a, coef_b, coef_c, coef_d, coef_e, coef_f,
                output ready);
endinterface

interface aff2d_out_if #(parameter int W = 32);
  logic                valid;
  logic                ready;
  logic signed [W-1:0] inv_a;
  logic signed [W-1:0] inv_b;
  logic signed [W-1:0] inv_c;
  logic signed [W-1:0] inv_d;
  logic signed [W-1:0] inv_e;
  logic signed [W-1:0] inv_f;
  logic                singular;
  logic                overflowed;
  modport source (output valid, inv_a, inv_b, inv_c, inv_d, inv_e, inv_f, singular,
                  overflowed, input ready);
  modport sink (input valid, inv_a, inv_b, inv_c, inv_d, inv_e, inv_f, singular,
                overflowed, output ready);
endinterface

// File: src/aff2d_front.sv
// Front end: products, determinant and cofactor sums, magnitudes and signs.
module aff2d_front
  import aff2d_pkg::*;
#(
  parameter int W = WORD_BITS_DEF,
  parameter int F = FRACTION_BITS_DEF
) (
  input  logic                   clk,
  input  logic [2:0]             en,
  input  logic signed [W-1:0]    a,
  input  logic signed [W-1:0]    b,
  input  logic signed [W-1:0]    c,
  input  logic signed [W-1:0]    d,
  input  logic signed [W-1:0]    e,
  input  logic signed [W-1:0]    f,
  output logic [num_bits(W, F)-1:0] num [LANES],
  output logic                   neg [LANES],
  output logic [2*W-1:0]         den,
  output logic                   zero
);

  localparam int PW = 2 * W;
  localparam int SW = 2 * W + 1;
  localparam int DW = 2 * W;
  localparam int NW = num_bits(W, F);

  logic signed [PW-1:0] ad, bc, cf, de, be, af;
  logic [W-1:0] a0, b0, c0, d0, a1, b1, c1, d1;
  logic [SW-1:0] det, ne, nf;

  function automatic logic [W-1:0] mag_word(input logic [W-1:0] x);
    return x[W-1] ? (~x + 1'b1) : x;
  endfunction

  function automatic logic [DW-1:0] mag_wide(input logic [SW-1:0] x);
    logic [SW-1:0] t;
    t = x[SW-1] ? (~x + 1'b1) : x;
    return t[DW-1:0];
  endfunction

  // Stage 0: the six products, operands sign-extended to the full product width
  always_ff @(posedge clk) begin
    if (en[0]) begin
      ad <= PW'(a) * PW'(d);
      bc <= PW'(b) * PW'(c);
      cf <= PW'(c) * PW'(f);
      de <= PW'(d) * PW'(e);
      be <= PW'(b) * PW'(e);
      af <= PW'(a) * PW'(f);
      a0 <= a;
      b0 <= b;
      c0 <= c;
      d0 <= d;
    end
  end

  // Stage 1: determinant and translation numerators, exact
  always_ff @(posedge clk) begin
    if (en[1]) begin
      det <= {ad[PW-1], ad} - {bc[PW-1], bc};
      ne  <= {cf[PW-1], cf} - {de[PW-1], de};
      nf  <= {be[PW-1], be} - {af[PW-1], af};
      a1  <= a0;
      b1  <= b0;
      c1  <= c0;
      d1  <= d0;
    end
  end

  // Stage 2: magnitudes, result signs, fixed-point alignment of numerators
  always_ff @(posedge clk) begin
    if (en[2]) begin
      num[LANE_A] <= NW'(mag_word(d1)) << (2 * F);
      num[LANE_B] <= NW'(mag_word(b1)) << (2 * F);
      num[LANE_C] <= NW'(mag_word(c1)) << (2 * F);
      num[LANE_D] <= NW'(mag_word(a1)) << (2 * F);
      num[LANE_E] <= NW'(mag_wide(ne)) << F;
      num[LANE_F] <= NW'(mag_wide(nf)) << F;
      neg[LANE_A] <= d1[W-1] ^ det[SW-1];
      neg[LANE_B] <= ~(b1[W-1] ^ det[SW-1]);
      neg[LANE_C] <= ~(c1[W-1] ^ det[SW-1]);
      neg[LANE_D] <= a1[W-1] ^ det[SW-1];
      neg[LANE_E] <= ne[SW-1] ^ det[SW-1];
      neg[LANE_F] <= nf[SW-1] ^ det[SW-1];
      den         <= mag_wide(det);
      zero        <= (det == '0);
    end
  end

endmodule

// File: src/aff2d_div.sv
// One divider lane: restoring division, one quotient bit per stage, then round and saturate.
module aff2d_div
  import aff2d_pkg::*;
#(
  parameter int W = WORD_BITS_DEF,
  parameter int F = FRACTION_BITS_DEF
) (
  input  logic                      clk,
  input  logic [W+2:0]              en,
  input  logic [num_bits(W, F)-1:0] num,
  input  logic                      neg,
  input  logic [2*W-1:0]            den,
  output logic [W-1:0]              q,
  output logic                      ovf
);

  localparam int NW  = num_bits(W, F);
  localparam int DW  = 2 * W;
  localparam int RW  = DW + 1;
  localparam int CW  = (NW > DW) ? NW : DW;
  localparam int QW  = W + 1;   // quotient bits kept; anything larger saturates
  localparam int QRW = W + 2;
  localparam int ST  = W + 1;

  logic [DW-1:0] rem [ST+1];
  logic [QW-1:0] nl  [ST+1];
  logic [QW-1:0] qq  [ST+1];
  logic [DW-1:0] dn  [ST+1];
  logic          sg  [ST+1];
  logic          bg  [ST+1];

  // Stage 0: detect a quotient too large for the kept bits, seed the remainder
  always_ff @(posedge clk) begin
    if (en[0]) begin
      bg[0]  <= CW'(num >> QW) >= CW'(den);
      rem[0] <= DW'(num >> QW);
      nl[0]  <= num[QW-1:0];
      qq[0]  <= '0;
      dn[0]  <= den;
      sg[0]  <= neg;
    end
  end

  // Division stages, most significant quotient bit first
  for (genvar k = 0; k < ST; k++) begin : g_step
    logic [RW-1:0] r2;
    logic [RW-1:0] df;
    logic          ge;
    assign r2 = {rem[k], nl[k][QW-1]};
    assign df = r2 - {1'b0, dn[k]};
    assign ge = r2 >= {1'b0, dn[k]};

    always_ff @(posedge clk) begin
      if (en[k+1]) begin
        rem[k+1] <= ge ? df[DW-1:0] : r2[DW-1:0];
        qq[k+1]  <= {qq[k][QW-2:0], ge};
        nl[k+1]  <= nl[k] << 1;
        dn[k+1]  <= dn[k];
        sg[k+1]  <= sg[k];
        bg[k+1]  <= bg[k];
      end
    end
  end

  // Final stage: round half away from zero, clamp, apply sign
  logic [RW-1:0]  rr;
  logic           up;
  logic [QRW-1:0] qr, lim, mag, res;
  logic           sat;

  always_comb begin
    rr  = {rem[ST], 1'b0};
    up  = rr >= {1'b0, dn[ST]};
    qr  = {1'b0, qq[ST]} + QRW'(up);
    lim = (QRW'(1) << (W - 1)) - QRW'(!sg[ST]);
    sat = bg[ST] || (qr > lim);
    mag = sat ? lim : qr;
    res = sg[ST] ? (~mag + 1'b1) : mag;
  end

  always_ff @(posedge clk) begin
    if (en[ST+1]) begin
      q   <= res[W-1:0];
      ovf <= sat;
    end
  end

endmodule

// File: src/affine_2d_inverse_core.sv
// Top level of the 2D affine transform inverse pipeline.
// Takes the six signed fixed-point coefficients of x' = a*x + c*y + e, y' = b*x + d*y + f
// and returns the inverse transform, each coefficient rounded to nearest (ties away from
// zero) and clamped to the word range, with overflowed set when any term clamped and
// singular set (all terms zero) when the determinant is zero. One item is accepted per
// clock unless the output stalls; the stages are 3 front stages (multiply, subtract,
// magnitude), WORD_BITS + 3 divider stages (seed, bit stages of one quotient bit, round)
// and the output register. Each stage advances when it is empty or its successor
// advances, so bubbles close up while the output waits and a stall drops nothing.
module affine_2d_inverse_core
  import aff2d_pkg::*;
#(
  parameter int WORD_BITS     = WORD_BITS_DEF,
  parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  aff2d_in_if.sink    xform,
  aff2d_out_if.source inverse
);

  localparam int W  = WORD_BITS;
  localparam int NW = num_bits(WORD_BITS, FRACTION_BITS);
  localparam int NS = W + 7;
  localparam int LS = W + 3;

  logic [NS-1:0] vld;
  logic [NS:0]   en;

  logic [NW-1:0]  num [LANES];
  logic           neg [LANES];
  logic [2*W-1:0] den;
  logic           zero;
  logic [W-1:0]   qv  [LANES];
  logic           ov  [LANES];
  logic [LS-1:0]  zp;

  logic [W-1:0] inv_a, inv_b, inv_c, inv_d, inv_e, inv_f;
  logic         singular, overflowed;

  // Stage enables: a stage moves when empty or when the one after it moves
  always_comb begin
    en[NS] = inverse.ready;
    for (int k = NS - 1; k >= 0; k--) begin
      en[k] = !vld[k] || en[k+1];
    end
  end

  assign xform.ready = en[0];

  // Valid bits travel with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) begin
        vld[0] <= xform.valid;
      end
      for (int k = 1; k < NS; k++) begin
        if (en[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  aff2d_front #(.W(W), .F(FRACTION_BITS)) u_front (
    .clk  (clk),
    .en   (en[2:0]),
    .a    (xform.coef_a),
    .b    (xform.coef_b),
    .c    (xform.coef_c),
    .d    (xform.coef_d),
    .e    (xform.coef_e),
    .f    (xform.coef_f),
    .num  (num),
    .neg  (neg),
    .den  (den),
    .zero (zero)
  );

  for (genvar i = 0; i < LANES; i++) begin : g_lane
    aff2d_div #(.W(W), .F(FRACTION_BITS)) u_div (
      .clk (clk),
      .en  (en[W+5:3]),
      .num (num[i]),
      .neg (neg[i]),
      .den (den),
      .q   (qv[i]),
      .ovf (ov[i])
    );
  end

  // Singular flag follows the divider lanes
  always_ff @(posedge clk) begin
    if (en[3]) begin
      zp[0] <= zero;
    end
    for (int k = 1; k < LS; k++) begin
      if (en[k+3]) begin
        zp[k] <= zp[k-1];
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (en[NS-1]) begin
      if (zp[LS-1]) begin
        inv_a      <= '0;
        inv_b      <= '0;
        inv_c      <= '0;
        inv_d      <= '0;
        inv_e      <= '0;
        inv_f      <= '0;
        singular   <= 1'b1;
        overflowed <= 1'b0;
      end else begin
        inv_a      <= qv[LANE_A];
        inv_b      <= qv[LANE_B];
        inv_c      <= qv[LANE_C];
        inv_d      <= qv[LANE_D];
        inv_e      <= qv[LANE_E];
        inv_f      <= qv[LANE_F];
        singular   <= 1'b0;
        overflowed <= ov[LANE_A] | ov[LANE_B] | ov[LANE_C] | ov[LANE_D] |
                      ov[LANE_E] | ov[LANE_F];
      end
    end
  end

  assign inverse.valid      = vld[NS-1];
  assign inverse.inv_a      = inv_a;
  assign inverse.inv_b      = inv_b;
  assign inverse.inv_c      = inv_c;
  assign inverse.inv_d      = inv_d;
  assign inverse.inv_e      = inv_e;
  assign inverse.inv_f      = inv_f;
  assign inverse.singular   = singular;
  assign inverse.overflowed = overflowed;

endmodule

// File: sim/tb_affine_2d_inverse_core.sv
// Self-checking testbench for the 2D affine inverse core: random and corner transforms.
`timescale 1ns / 100ps

module tb_affine_2d_inverse_core;
  import aff2d_pkg::*;

  localparam int W        = 32;
  localparam int FB       = 16;
  localparam int LATENCY  = W + 7;
  localparam int MAX_CYC  = 400000;
  localparam logic signed [W-1:0] S_MAX = 32'sh7fffffff;
  localparam logic signed [W-1:0] S_MIN = 32'sh80000000;
  localparam logic signed [W-1:0] ONE   = 32'sh00010000;

  typedef struct {
    logic signed [W-1:0] a, b, c, d, e, f;
  } xform_t;

  typedef struct {
    logic signed [W-1:0] a, b, c, d, e, f;
    logic                singular;
    logic                overflowed;
  } inverse_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  aff2d_in_if  #(.W(W)) xform ();
  aff2d_out_if #(.W(W)) inverse ();

  affine_2d_inverse_core #(.WORD_BITS(W), .FRACTION_BITS(FB)) i_dut (
    .clk     (clk),
    .rst     (rst),
    .xform   (xform.sink),
    .inverse (inverse.source)
  );

  always #10 clk = ~clk;

  xform_t   xform_q[$];
  inverse_t inverse_q[$];
  int       src_idle_pct = 0;
  int       snk_idle_pct = 0;
  bit       hold_start   = 1'b0;
  int       hold_cnt     = 0;
  bit       taken        = 1'b0;
  int       errors       = 0;
  int       cycles       = 0;

  // Rounded (ties away from zero), saturated quotient of (num << sh) / den
  function automatic logic [W-1:0] round_div(input logic signed [127:0] num, input int sh,
                                              input logic signed [127:0] den,
                                              input bit flip, inout bit ovf);
    logic [127:0] nm, dm, q, r, lim;
    bit neg;
    neg = ((num < 0) != (den < 0)) != flip;
    nm  = (num < 0) ? -num : num;
    dm  = (den < 0) ? -den : den;
    nm  = nm << sh;
    q   = nm / dm;
    r   = nm % dm;
    if ((r << 1) >= dm) q = q + 1;
    lim = neg ? (128'd1 << (W - 1)) : ((128'd1 << (W - 1)) - 1);
    if (q > lim) begin
      q   = lim;
      ovf = 1'b1;
    end
    return neg ? -q[W-1:0] : q[W-1:0];
  endfunction

  function automatic inverse_t invert(input xform_t t);
    logic signed [127:0] a, b, c, d, e, f, det;
    inverse_t r;
    bit ovf;
    a = t.a; b = t.b; c = t.c; d = t.d; e = t.e; f = t.f;
    det = a * d - b * c;
    ovf = 1'b0;
    r = '{default: '0};
    if (det == 0) begin
      r.singular = 1'b1;
      return r;
    end
    r.a = round_div(d, 2 * FB, det, 1'b0, ovf);
    r.b = round_div(b, 2 * FB, det, 1'b1, ovf);
    r.c = round_div(c, 2 * FB, det, 1'b1, ovf);
    r.d = round_div(a, 2 * FB, det, 1'b0, ovf);
    r.e = round_div(c * f - d * e, FB, det, 1'b0, ovf);
    r.f = round_div(b * e - a * f, FB, det, 1'b0, ovf);
    r.overflowed = ovf;
    return r;
  endfunction

  function automatic logic signed [W-1:0] any_word();
    case ($urandom_range(5))
      0: return S_MAX;
      1: return S_MIN;
      2: return $signed($urandom_range(8)) - 4;
      default: return $urandom;
    endcase
  endfunction

  // Coefficient of random sign: a whole value 0..4 plus a fraction in [-0.5, 0.5)
  function automatic logic signed [W-1:0] near_unit();
    logic signed [W-1:0] v;
    v = ONE * $signed($urandom_range(4)) + $signed($urandom_range(65535)) - 32768;
    return $urandom_range(1) ? -v : v;
  endfunction

  function automatic xform_t random_xform();
    xform_t t;
    logic signed [W-1:0] k;
    case ($urandom_range(9))
      // fully random words
      0, 1: begin
        t.a = $urandom; t.b = $urandom; t.c = $urandom;
        t.d = $urandom; t.e = $urandom; t.f = $urandom;
      end
      // corner mix
      2: begin
        t.a = any_word(); t.b = any_word(); t.c = any_word();
        t.d = any_word(); t.e = any_word(); t.f = any_word();
      end
      // rank-deficient: one column is a multiple of the other
      3: begin
        k = $signed($urandom_range(6)) - 3;
        t.c = $urandom; t.d = $urandom;
        if ($urandom_range(1)) begin
          t.c = t.c >>> 4; t.d = t.d >>> 4;
        end
        t.a = t.c * k; t.b = t.d * k;
        t.e = $urandom; t.f = $urandom;
      end
      // tiny determinant, quotients saturate
      4: begin
        t.a = $signed($urandom_range(6)) - 3; t.d = $signed($urandom_range(6)) - 3;
        t.b = $signed($urandom_range(2)) - 1; t.c = $signed($urandom_range(2)) - 1;
        t.e = any_word(); t.f = any_word();
      end
      // well-conditioned geometry transforms
      default: begin
        t.a = near_unit(); t.d = near_unit();
        t.b = near_unit() >>> $urandom_range(4);
        t.c = near_unit() >>> $urandom_range(4);
        t.e = $signed($urandom) >>> $urandom_range(16);
        t.f = $signed($urandom) >>> $urandom_range(16);
      end
    endcase
    return t;
  endfunction

  task automatic add_xform(input logic signed [W-1:0] a, b, c, d, e, f);
    xform_t t;
    t.a = a; t.b = b; t.c = c; t.d = d; t.e = e; t.f = f;
    xform_q.push_back(t);
  endtask

  task automatic add_random(input int n);
    repeat (n) xform_q.push_back(random_xform());
  endtask

  task automatic wait_drained();
    while (xform_q.size() != 0 || (xform.valid && !taken) || inverse_q.size() != 0)
      @(posedge clk);
  endtask

  // Driver: offer the next pending item at the falling edge
  always @(negedge clk) begin
    xform_t t;
    logic v;
    v = xform.valid;
    if (rst) begin
      v = 1'b0;
    end else if (!xform.valid || taken) begin
      v = 1'b0;
      if (xform_q.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
        t = xform_q.pop_front();
        xform.coef_a <= t.a; xform.coef_b <= t.b; xform.coef_c <= t.c;
        xform.coef_d <= t.d; xform.coef_e <= t.e; xform.coef_f <= t.f;
        v = 1'b1;
      end
    end
    taken = 1'b0;
    xform.valid <= v;
  end

  // Result receiver with random stalls and an occasional long hold-off
  always @(negedge clk) begin
    if (hold_start) begin
      hold_start = 1'b0;
      hold_cnt   = 300;
    end
    if (rst) begin
      inverse.ready <= 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt--;
      inverse.ready <= 1'b0;
    end else begin
      inverse.ready <= ($urandom_range(99) >= snk_idle_pct);
    end
  end

  // Input acceptance: predict the inverse
  always @(posedge clk) begin
    xform_t t;
    if (!rst && xform.valid && xform.ready) begin
      t.a = xform.coef_a; t.b = xform.coef_b; t.c = xform.coef_c;
      t.d = xform.coef_d; t.e = xform.coef_e; t.f = xform.coef_f;
      inverse_q.push_back(invert(t));
      taken = 1'b1;
    end
  end

  // Output check against the oldest prediction
  always @(posedge clk) begin
    inverse_t x;
    if (!rst && inverse.valid && inverse.ready) begin
      if (inverse_q.size() == 0) begin
        $error("unexpected inverse item");
        errors++;
      end else begin
        x = inverse_q.pop_front();
        if (inverse.inv_a !== x.a) begin
          $error("inv_a exp %0d got %0d", x.a, inverse.inv_a); errors++;
        end
        if (inverse.inv_b !== x.b) begin
          $error("inv_b exp %0d got %0d", x.b, inverse.inv_b); errors++;
        end
        if (inverse.inv_c !== x.c) begin
          $error("inv_c exp %0d got %0d", x.c, inverse.inv_c); errors++;
        end
        if (inverse.inv_d !== x.d) begin
          $error("inv_d exp %0d got %0d", x.d, inverse.inv_d); errors++;
        end
        if (inverse.inv_e !== x.e) begin
          $error("inv_e exp %0d got %0d", x.e, inverse.inv_e); errors++;
        end
        if (inverse.inv_f !== x.f) begin
          $error("inv_f exp %0d got %0d", x.f, inverse.inv_f); errors++;
        end
        if (inverse.singular !== x.singular) begin
          $error("singular exp %0b got %0b", x.singular, inverse.singular); errors++;
        end
        if (inverse.overflowed !== x.overflowed) begin
          $error("overflowed exp %0b got %0b", x.overflowed, inverse.overflowed); errors++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > MAX_CYC) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    xform.valid = 1'b0;
    xform.coef_a = '0; xform.coef_b = '0; xform.coef_c = '0;
    xform.coef_d = '0; xform.coef_e = '0; xform.coef_f = '0;
    inverse.ready = 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed corners: identity, zero, word extremes, singular, saturation
    add_xform(ONE, 0, 0, ONE, 0, 0);
    add_xform(ONE, 0, 0, ONE, S_MAX, S_MIN);
    add_xform(0, 0, 0, 0, 0, 0);
    add_xform(S_MAX, S_MAX, S_MAX, S_MAX, S_MAX, S_MAX);
    add_xform(S_MIN, S_MIN, S_MIN, S_MIN, S_MIN, S_MIN);
    add_xform(S_MIN, 0, 0, S_MIN, S_MAX, S_MIN);
    add_xform(S_MAX, S_MIN, S_MIN, S_MAX, S_MIN, S_MAX);
    add_xform(1, 0, 0, 1, 1, -1);
    add_xform(-1, 0, 0, -1, S_MAX, S_MAX);
    add_xform(0, ONE, ONE, 0, ONE, -ONE);
    add_xform(2 * ONE, 0, 0, 2 * ONE, 3, -3);
    add_xform(3 * ONE, ONE, ONE, 3 * ONE, 1, 1);
    add_xform(ONE, 2 * ONE, ONE, 2 * ONE, 5, 7);
    add_xform(-ONE, ONE, 0, -ONE, -1, -1);
    add_xform(0, 1, 1, 0, 0, 0);
    add_xform(S_MIN, S_MAX, S_MAX, S_MIN, 0, 0);
    add_xform(-1, -1, -1, -1, -1, -1);
    add_xform(ONE, 0, 0, -ONE, S_MIN, S_MAX);

    // Phase 1: busy sender, slow receiver
    src_idle_pct = 34; snk_idle_pct = 85;
    add_random(600);
    wait_drained();

    // Phase 2: slow sender, fast receiver
    src_idle_pct = 85; snk_idle_pct = 34;
    add_random(600);
    wait_drained();

    // Phase 3: no idling, with a long receiver hold-off and a sender pause
    src_idle_pct = 0; snk_idle_pct = 0;
    add_random(150);
    hold_start = 1'b1;
    add_random(200);
    wait_drained();
    add_random(350);

    wait_drained();
    repeat (LATENCY + 10) @(posedge clk);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
